@@ rtl/core/sgb_pkg.sv @@
// shared types, constants and coefficient construction for the separable gaussian blur unit
package sgb_pkg;

   // fixed field widths
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 16;
   localparam int PIXEL_W = 32;
   localparam int CFG_W   = 9;
   localparam int CSR_IDX_W = 1;

   // default build parameters
   localparam int MAX_DIM_DEF       = 256;
   localparam int KERNEL_RADIUS_DEF = 47;
   localparam int COEF_BITS_DEF     = 16;

   // register reset value for both dimensions
   localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // gaussian weight construction (sigma 15.5, 2*sigma^2 = 961/2)
   localparam int GAUSS_NUM    = 2;
   localparam int GAUSS_DEN    = 961;
   localparam int WEIGHT_FRAC  = 30;
   localparam int SERIES_TERMS = 16;
   localparam int RADIUS_LIMIT = 64;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD = 2'd0,
      MODE_BLUR = 2'd1,
      MODE_READ = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_TAP,
      ST_DRAIN,
      ST_WRITE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic blur_start;
      logic tap_issue;
      logic write_px;
      logic read_capture;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tap_last;
      logic pix_last;
      logic pass_vert;
   } stat_type;

   // shift and subtract quotient, only used while the coefficient rom is built
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // normalised q0.coef_bits coefficient for tap distance idx, evaluated at elaboration
   function automatic logic [63:0] gauss_coef(input int idx, input int radius,
                                              input int coef_bits);
      logic [63:0] w [0:RADIUS_LIMIT];
      logic [63:0] one;
      logic [63:0] n;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] sum;
      int i;
      int k;
      one = 64'd1 << WEIGHT_FRAC;
      w[0] = one;
      for (i = 1; i <= RADIUS_LIMIT; i++) begin
         if (i <= radius) begin
            n = 64'(GAUSS_NUM * (2 * i - 1));
            term = one;
            pos = one;
            neg = 64'd0;
            // taylor series of exp(-x) in q30
            for (k = 1; k < SERIES_TERMS; k++) begin
               term = udiv64(term * n, 64'(GAUSS_DEN) * 64'(k));
               if ((k & 1) != 0) begin
                  neg = neg + term;
               end else begin
                  pos = pos + term;
               end
            end
            w[i] = (w[i-1] * (pos - neg)) >> WEIGHT_FRAC;
         end else begin
            w[i] = 64'd0;
         end
      end
      sum = w[0];
      for (i = 1; i <= RADIUS_LIMIT; i++) begin
         sum = sum + (w[i] << 1);
      end
      return udiv64((w[idx] << coef_bits) + (sum >> 1), sum);
   endfunction

endpackage

@@ rtl/core/sgb_if.sv @@
// request and response channel interfaces of the blur unit
interface sgb_req_if import sgb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [INDEX_W-1:0] pixel_index;
   logic [PIXEL_W-1:0] pixel_value;

   modport source (output valid, output mode, output pixel_index, output pixel_value,
                   input ready);
   modport sink (input valid, input mode, input pixel_index, input pixel_value,
                 output ready);
endinterface

interface sgb_rsp_if import sgb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] read_value;
   logic               status;

   modport source (output valid, output read_value, output status, input ready);
   modport sink (input valid, input read_value, input status, output ready);
endinterface

@@ rtl/core/separable_gaussian_blur_rgba_unit.sv @@
// top level of the separable gaussian blur unit over an rgba8 frame store
//
//   channel   direction  handshake        payload
//   req       in         valid / ready    mode, pixel_index, pixel_value
//   rsp       out        valid / ready    read_value, status
//   csr       in         csr_wr_en        csr_index, csr_wr_data
//
// load and unused modes answer on acceptance, a read after one registered memory read.
// a blur runs a horizontal and then a vertical pass: one tap read a cycle
// through one memory read port, then a drain and a write state per pixel.
// reset clears control and dimension registers only; memories hold nothing until loaded.
// a request is taken only while idle and the response register is free or being drained.
module separable_gaussian_blur_rgba_unit import sgb_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int KERNEL_RADIUS = KERNEL_RADIUS_DEF,
   parameter int COEF_BITS     = COEF_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   sgb_req_if.sink              req,
   sgb_rsp_if.source            rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   sgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and arithmetic
   sgb_datapath #(
      .MAX_DIM       (MAX_DIM),
      .KERNEL_RADIUS (KERNEL_RADIUS),
      .COEF_BITS     (COEF_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_mode        (req.mode),
      .req_pixel_index (req.pixel_index),
      .req_pixel_value (req.pixel_value),
      .rsp_read_value  (rsp.read_value),
      .rsp_status      (rsp.status),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

@@ rtl/core/sgb_ctrl.sv @@
// controller state machine: request sequencing, blur pass stepping and response valid
module sgb_ctrl import sgb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  stat_type          stat,
   output cmd_type           cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   mode_type  mode;

   assign mode = mode_type'(req_mode);

   // request taken only when idle and the response slot frees
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && mode == MODE_BLUR) begin
               state_in = ST_TAP;
            end else if (accept && mode == MODE_READ) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_TAP: begin
            if (stat.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: begin
            if (stat.pix_last && stat.pass_vert) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_TAP;
            end
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      cmd.accept       = accept;
      cmd.blur_start   = accept && (mode == MODE_BLUR);
      cmd.tap_issue    = (state_ff == ST_TAP);
      cmd.write_px     = (state_ff == ST_WRITE);
      cmd.read_capture = (state_ff == ST_READ);
   end

   // response valid: immediate for load and unused modes, later for read and blur
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((accept && mode != MODE_BLUR && mode != MODE_READ) ||
          state_ff == ST_READ || state_ff == ST_DONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   a_blur_enters_taps: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_BLUR |=> state_ff == ST_TAP)
      else $error("blur request did not start the tap sequence");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while a response is still held");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ) || $past(state_ff == ST_DONE) ||
                              $past(req_valid && req_ready))
      else $error("response raised without a cause");

   a_blur_slot_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> !rsp_valid_ff)
      else $error("response pending during blur");

endmodule

@@ rtl/core/sgb_datapath.sv @@
// datapath: frame and scratch memories, tap address generation, coefficient rom, accumulators
module sgb_datapath import sgb_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int KERNEL_RADIUS = KERNEL_RADIUS_DEF,
   parameter int COEF_BITS     = COEF_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [INDEX_W-1:0]   req_pixel_index,
   input  logic [PIXEL_W-1:0]   req_pixel_value,
   output logic [PIXEL_W-1:0]   rsp_read_value,
   output logic                 rsp_status,
   input  cmd_type              cmd,
   output stat_type             stat
);

   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int AREA_W    = 2 * DIM_W;
   localparam int CMP_W     = (AREA_W > INDEX_W) ? AREA_W : INDEX_W;
   localparam int TAPS      = 2 * KERNEL_RADIUS + 1;
   localparam int TAP_W     = $clog2(TAPS);
   localparam int RAD_W     = $clog2(KERNEL_RADIUS + 1);
   localparam int SUM_W     = ((DIM_W > TAP_W) ? DIM_W : TAP_W) + 2;
   localparam int ACC_W     = COEF_BITS + 10;

   // configuration registers
   logic [CFG_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // effective dimensions: zero reads as one, large values clip to the maximum
   logic [DIM_W-1:0]  eff_w, eff_h;
   logic [AREA_W-1:0] area;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_DIM)) begin
         eff_w = DIM_W'(MAX_DIM);
      end else begin
         eff_w = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = DIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_DIM)) begin
         eff_h = DIM_W'(MAX_DIM);
      end else begin
         eff_h = DIM_W'(height_ff);
      end
   end

   assign area = AREA_W'(eff_w) * AREA_W'(eff_h);

   // request decode
   mode_type          mode;
   logic              in_range;
   logic [ADDR_W-1:0] idx_addr;

   assign mode     = mode_type'(req_mode);
   assign in_range = CMP_W'(req_pixel_index) < CMP_W'(area);
   assign idx_addr = ADDR_W'(req_pixel_index);

   // blur position counters
   logic             pass_ff;
   logic [IDX_W-1:0] line_ff, pos_ff;
   logic [TAP_W-1:0] tap_ff;
   logic [DIM_W-1:0] len, lines;
   logic             pos_last, line_last;

   assign len       = pass_ff ? eff_h : eff_w;
   assign lines     = pass_ff ? eff_w : eff_h;
   assign pos_last  = (DIM_W'(pos_ff) + DIM_W'(1)) == len;
   assign line_last = (DIM_W'(line_ff) + DIM_W'(1)) == lines;

   assign stat.tap_last  = (tap_ff == TAP_W'(TAPS - 1));
   assign stat.pix_last  = pos_last && line_last;
   assign stat.pass_vert = pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b0;
         line_ff <= '0;
         pos_ff  <= '0;
         tap_ff  <= '0;
      end else if (cmd.blur_start) begin
         pass_ff <= 1'b0;
         line_ff <= '0;
         pos_ff  <= '0;
         tap_ff  <= '0;
      end else if (cmd.write_px) begin
         tap_ff <= '0;
         if (pos_last) begin
            pos_ff <= '0;
            if (line_last) begin
               line_ff <= '0;
               pass_ff <= ~pass_ff;
            end else begin
               line_ff <= line_ff + IDX_W'(1);
            end
         end else begin
            pos_ff <= pos_ff + IDX_W'(1);
         end
      end else if (cmd.tap_issue) begin
         tap_ff <= tap_ff + TAP_W'(1);
      end
   end

   // tap position with clamp to edge
   logic signed [SUM_W-1:0] tap_pos;
   logic [IDX_W-1:0]        tap_clamped, p_sel, mul_a, mul_b;
   logic [AREA_W-1:0]       addr_sum;
   logic [ADDR_W-1:0]       gen_addr;

   assign tap_pos = $signed(SUM_W'(pos_ff)) + $signed(SUM_W'(tap_ff))
                    - $signed(SUM_W'(KERNEL_RADIUS));

   always_comb begin
      if (tap_pos[SUM_W-1]) begin
         tap_clamped = '0;
      end else if (tap_pos >= $signed(SUM_W'(len))) begin
         tap_clamped = IDX_W'(len - DIM_W'(1));
      end else begin
         tap_clamped = IDX_W'(tap_pos);
      end
   end

   // row-major address: row times width plus column
   assign p_sel    = cmd.tap_issue ? tap_clamped : pos_ff;
   assign mul_a    = pass_ff ? p_sel : line_ff;
   assign mul_b    = pass_ff ? line_ff : p_sel;
   assign addr_sum = AREA_W'(mul_a) * AREA_W'(eff_w) + AREA_W'(mul_b);
   assign gen_addr = ADDR_W'(addr_sum);

   // coefficient rom built at elaboration
   logic [COEF_BITS-1:0] coef_rom [KERNEL_RADIUS+1];

   for (genvar g = 0; g <= KERNEL_RADIUS; g++) begin : g_coef
      localparam logic [63:0] COEF_VAL = gauss_coef(g, KERNEL_RADIUS, COEF_BITS);
      assign coef_rom[g] = COEF_VAL[COEF_BITS-1:0];
   end

   logic [TAP_W-1:0] tap_dist;
   logic [RAD_W-1:0] rom_idx;

   assign tap_dist = (tap_ff >= TAP_W'(KERNEL_RADIUS)) ? tap_ff - TAP_W'(KERNEL_RADIUS)
                                                       : TAP_W'(KERNEL_RADIUS) - tap_ff;
   assign rom_idx  = RAD_W'(tap_dist);

   // memories
   logic [PIXEL_W-1:0] frame_mem   [MEM_DEPTH];
   logic [PIXEL_W-1:0] scratch_mem [MEM_DEPTH];
   logic [PIXEL_W-1:0] frame_q_ff, scratch_q_ff;
   logic [PIXEL_W-1:0] filt;
   logic               load_we, frame_we, scratch_we;
   logic [ADDR_W-1:0]  frame_waddr, frame_raddr;
   logic [PIXEL_W-1:0] frame_wdata;

   assign load_we     = cmd.accept && (mode == MODE_LOAD) && in_range;
   assign frame_we    = load_we || (cmd.write_px && pass_ff);
   assign frame_waddr = load_we ? idx_addr : gen_addr;
   assign frame_wdata = load_we ? req_pixel_value : filt;
   assign frame_raddr = cmd.tap_issue ? gen_addr : idx_addr;
   assign scratch_we  = cmd.write_px && !pass_ff;

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      frame_q_ff <= frame_mem[frame_raddr];
   end

   always_ff @(posedge clock) begin
      if (scratch_we) begin
         scratch_mem[gen_addr] <= filt;
      end
      scratch_q_ff <= scratch_mem[gen_addr];
   end

   // coefficient is registered alongside the memory read data
   logic [COEF_BITS-1:0] coef_ff;
   logic                 tap_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff <= 1'b0;
      end else begin
         tap_vld_ff <= cmd.tap_issue;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_rom[rom_idx];
   end

   // per-channel multiply-accumulate
   logic [PIXEL_W-1:0] src_q;
   logic [ACC_W-1:0]   acc_ff [4];
   logic [ACC_W-1:0]   acc_in [4];

   assign src_q = pass_ff ? scratch_q_ff : frame_q_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (cmd.blur_start || cmd.write_px) begin
            acc_in[c] = '0;
         end else if (tap_vld_ff) begin
            acc_in[c] = acc_ff[c] + ACC_W'(coef_ff) * ACC_W'(src_q[8*c +: 8]);
         end else begin
            acc_in[c] = acc_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         acc_ff[c] <= acc_in[c];
      end
   end

   // truncate and saturate each channel
   always_comb begin
      logic [ACC_W-1:0] shifted;
      shifted = '0;
      for (int c = 0; c < 4; c++) begin
         shifted = acc_ff[c] >> COEF_BITS;
         filt[8*c +: 8] = (shifted > ACC_W'(255)) ? 8'hFF : shifted[7:0];
      end
   end

   // response payload
   logic [PIXEL_W-1:0] rsp_value_ff;
   logic               rsp_status_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsp_value_ff  <= '0;
         rsp_status_ff <= ((mode == MODE_LOAD) || (mode == MODE_READ)) && !in_range;
      end else if (cmd.read_capture) begin
         rsp_value_ff <= rsp_status_ff ? '0 : frame_q_ff;
      end
   end

   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
